[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The consequent must hold in the cycle after the antecedent; checked on every
// clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: unconditional implication");

`endif

[rtl/dst_pkg.sv]
// ----------------------------------------------------------------------------
// Delimiter tokenizer package
// Types, constants and helper functions shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package dst_pkg;

    // Width of the string position counter and of the reported fields.
    localparam int POS_BITS = 16;
    localparam int OUT_BITS = 16;
    localparam int EXT_BITS = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // Text byte that terminates a string.
    localparam logic [7:0] NUL_BYTE = 8'h00;

    // Queue between the classifier and the token engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Input item operations.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_TEXT  = 2'd2
    } t_opcode;

    // Class of a text byte as seen by the token engine.
    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_DELIM = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // One queue entry, with its valid flag.
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic                found;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic                last;
        logic                sat;
    } t_result;

    // Saturate a position value to the output field width.
    function automatic logic [OUT_BITS-1:0] f_clamp(input logic [POS_BITS-1:0] v);
        logic [EXT_BITS-1:0] w;
        w = EXT_BITS'(v);
        if (w > EXT_BITS'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

[rtl/dst_front.sv]
// ----------------------------------------------------------------------------
// Tokenizer front end
// Holds the delimiter bitmap, applies set edits and classifies text bytes.
// ----------------------------------------------------------------------------
module dst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dst_pkg::t_opcode  i_opcode,
    input  logic [7:0]        i_byte,
    output dst_pkg::t_entry   o_push
);
    import dst_pkg::*;

    logic [255:0] r_delim_map;
    logic [255:0] n_delim_map;

    // Bitmap edits; a clear empties the whole set at once.
    always_comb begin
        n_delim_map = r_delim_map;
        if (i_accept) begin
            case (i_opcode)
                OP_CLEAR: n_delim_map = '0;
                OP_ADD:   n_delim_map[i_byte] = 1'b1;
                default:  n_delim_map = r_delim_map;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_map <= '0;
        end else begin
            r_delim_map <= n_delim_map;
        end
    end

    // Text bytes are classified against the set as it stands before this item.
    always_comb begin
        o_push.valid = i_accept && (i_opcode == OP_TEXT);
        if (i_byte == NUL_BYTE) begin
            o_push.kind = KIND_END;
        end else if (r_delim_map[i_byte]) begin
            o_push.kind = KIND_DELIM;
        end else begin
            o_push.kind = KIND_WORD;
        end
    end

endmodule

[rtl/dst_queue.sv]
// ----------------------------------------------------------------------------
// Tokenizer class queue
// Short first-in first-out buffer of classified text bytes.
// ----------------------------------------------------------------------------
module dst_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dst_pkg::t_entry   i_push,
    output logic              o_ready,
    output dst_pkg::t_entry   o_head,
    input  logic              i_pop
);
    import dst_pkg::*;

    t_kind                r_kind [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready     = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign w_push      = i_push.valid && o_ready;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.kind  = r_kind[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + QPTR_BITS'(1);
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wr_ptr] <= i_push.kind;
        end
    end

endmodule

[rtl/dst_back.sv]
// ----------------------------------------------------------------------------
// Tokenizer token engine
// Tracks the scan position and token state and builds the result items.
// ----------------------------------------------------------------------------
module dst_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dst_pkg::t_entry   i_head,
    output logic              o_pop,
    output logic              o_valid,
    output dst_pkg::t_result  o_result,
    input  logic              i_ready
);
    import dst_pkg::*;

    logic                r_inside;
    logic [POS_BITS-1:0] r_begin;
    logic [POS_BITS-1:0] r_pos;
    logic                r_sat;
    logic                r_out_valid;
    t_result             r_out;

    logic                n_inside;
    logic [POS_BITS-1:0] n_begin;
    logic [POS_BITS-1:0] n_pos;
    logic                n_sat;
    logic                n_out_valid;
    t_result             n_out;

    logic                w_produces;
    logic                w_slot_free;
    logic [POS_BITS-1:0] w_length;
    logic [POS_BITS-1:0] w_pos_next;
    logic                w_pos_full;

    assign w_produces  = (i_head.kind == KIND_END) ||
                         ((i_head.kind == KIND_DELIM) && r_inside);
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = i_head.valid && (!w_produces || w_slot_free);
    assign w_length    = r_pos - r_begin;
    assign w_pos_full  = (r_pos == POS_MAX);
    assign w_pos_next  = w_pos_full ? r_pos : r_pos + POS_BITS'(1);

    // Token state update and result construction for the popped byte.
    always_comb begin
        n_inside    = r_inside;
        n_begin     = r_begin;
        n_pos       = r_pos;
        n_sat       = r_sat;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop) begin
            case (i_head.kind)
                KIND_END: begin
                    n_out.found  = r_inside;
                    n_out.start  = r_inside ? f_clamp(r_begin) : '0;
                    n_out.length = r_inside ? f_clamp(w_length) : '0;
                    n_out.last   = 1'b1;
                    n_out.sat    = r_sat;
                    n_out_valid  = 1'b1;
                    n_inside     = 1'b0;
                    n_begin      = '0;
                    n_pos        = '0;
                    n_sat        = 1'b0;
                end
                KIND_DELIM: begin
                    if (r_inside) begin
                        n_out.found  = 1'b1;
                        n_out.start  = f_clamp(r_begin);
                        n_out.length = f_clamp(w_length);
                        n_out.last   = 1'b0;
                        n_out.sat    = r_sat;
                        n_out_valid  = 1'b1;
                    end
                    n_inside = 1'b0;
                    n_pos    = w_pos_next;
                    n_sat    = r_sat || w_pos_full;
                end
                default: begin
                    if (!r_inside) begin
                        n_inside = 1'b1;
                        n_begin  = r_pos;
                    end
                    n_pos = w_pos_next;
                    n_sat = r_sat || w_pos_full;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_begin     <= '0;
            r_pos       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inside    <= n_inside;
            r_begin     <= n_begin;
            r_pos       <= n_pos;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/delimiter_set_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// Delimiter-set tokenizer
// Splits a NUL-terminated byte stream into tokens separated by delimiter runs.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the queue has room. A clear or
// add item edits the 256-entry delimiter bitmap, which is held in flip-flops
// and cleared all at once, so no clearing pass is needed after reset. A text
// byte is classified against the bitmap on acceptance and queued; the token
// engine takes one queued byte per cycle while the output register can take
// any result that byte causes, and that result is loaded into the output
// register once it is free. The front end stalls only when the two-entry
// queue is full, which happens when results are held back by the output side.
module delimiter_set_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [1:0]  o_m_tuser,   // [0] token_found, [1] position_saturated
    output logic        o_m_tlast    // string_end
);
    import dst_pkg::*;

    t_entry  w_push;
    t_entry  w_head;
    logic    w_pop;
    logic    w_accept;
    t_result w_result;

    assign w_accept = i_s_tvalid && o_s_tready;

    // Classifier with the delimiter bitmap.
    dst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_opcode (t_opcode'(i_s_tuser)),
        .i_byte   (i_s_tdata),
        .o_push   (w_push)
    );

    // Queue between classifier and token engine.
    dst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (o_s_tready),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Token engine with the output register.
    dst_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .o_result (w_result),
        .i_ready  (i_m_tready)
    );

    // Pack the result item onto the output channel.
    assign o_m_tdata = {w_result.length, w_result.start};
    assign o_m_tuser = {w_result.sat, w_result.found};
    assign o_m_tlast = w_result.last;

endmodule

[rtl/dst_checker.sv]
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports of the tokenizer for inconsistent results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // An empty end marker carries a zero start and a zero length.
    `ASSERT_SAME(a_empty_marker_zero, i_clk, i_rst_n,
                 o_m_tvalid && !o_m_tuser[0], o_m_tdata == 32'd0)

    // Only the string end may report no token; a delimiter always closes one.
    `ASSERT_SAME(a_mid_string_found, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tuser[0])

    // A stalled result stays offered with the same contents.
    `ASSERT_NEXT(a_out_hold, i_clk, o_m_tvalid && !i_m_tready,
                 o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast),
                 i_rst_n)

    // Nothing is offered in the cycle after a reset edge.
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind delimiter_set_tokenizer_core dst_checker u_dst_checker (.*);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Delimiter-set tokenizer testbench
// Feeds bitmap edits and text bytes to the tokenizer core and predicts every
// token report in a behavioural model of its own. Each reported item is
// checked field by field against the oldest prediction. The run has three
// phases with different amounts of idling on each side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dst_pkg::*;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 400;

    typedef struct {
        logic [1:0] op;
        logic [7:0] value;
    } t_feed_item;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [7:0] byte_value
    logic [1:0]  i_s_tuser = '0;   // [1:0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [15:0] token_start, [31:16] token_length
    logic [1:0]  o_m_tuser;        // [0] token_found, [1] position_saturated
    logic        o_m_tlast;        // string_end

    // Items waiting to be driven, and token reports still to arrive.
    t_feed_item  pending_bytes[$];
    t_result     expected_tokens[$];
    logic [7:0]  delim_choices[$];

    // Shadow copy of the tokenizer state.
    logic [255:0]         delim_map = '0;
    logic                 in_token = 1'b0;
    logic [POS_BITS-1:0]  tok_begin = '0;
    logic [POS_BITS-1:0]  scan_pos = '0;
    logic                 sat_flag = 1'b0;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int planned_items = 0;
    int items_accepted = 0;
    int tokens_checked = 0;
    int saturated_reports = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    delimiter_set_tokenizer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Saturate a position to the width of the reported fields.
    function automatic logic [OUT_BITS-1:0] fit_out(input logic [POS_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w > 64'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return w[OUT_BITS-1:0];
    endfunction

    // Move to the next offset, or stick at the top and raise the flag.
    function automatic void step_position();
        if (scan_pos == POS_MAX) begin
            sat_flag = 1'b1;
        end else begin
            scan_pos = scan_pos + POS_BITS'(1);
        end
    endfunction

    // Apply one accepted item to the shadow state; returns 1 with the token
    // report in rpt when the item causes one.
    function automatic bit tokenize_byte(input logic [1:0] op, input logic [7:0] b,
                                         output t_result rpt);
        bit reported;
        reported = 1'b0;
        rpt = '0;
        case (op)
            OP_CLEAR: begin
                delim_map = '0;
            end
            OP_ADD: begin
                delim_map[b] = 1'b1;
            end
            OP_TEXT: begin
                if (b == NUL_BYTE) begin
                    // The terminator closes the open token or gives an empty marker.
                    rpt.found  = in_token;
                    rpt.start  = in_token ? fit_out(tok_begin) : '0;
                    rpt.length = in_token ? fit_out(scan_pos - tok_begin) : '0;
                    rpt.last   = 1'b1;
                    rpt.sat    = sat_flag;
                    in_token   = 1'b0;
                    tok_begin  = '0;
                    scan_pos   = '0;
                    sat_flag   = 1'b0;
                    reported   = 1'b1;
                end else if (delim_map[b]) begin
                    if (in_token) begin
                        rpt.found  = 1'b1;
                        rpt.start  = fit_out(tok_begin);
                        rpt.length = fit_out(scan_pos - tok_begin);
                        rpt.sat    = sat_flag;
                        in_token   = 1'b0;
                        reported   = 1'b1;
                    end
                    step_position();
                end else begin
                    if (!in_token) begin
                        in_token  = 1'b1;
                        tok_begin = scan_pos;
                    end
                    step_position();
                end
            end
            default: begin
            end
        endcase
        return reported;
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [7:0] value);
        t_feed_item it;
        it.op = op;
        it.value = value;
        pending_bytes.push_back(it);
        if (op != OP_UNUSED) begin
            planned_items++;
        end
    endtask

    // A text byte that is often one of the current delimiters.
    function automatic logic [7:0] pick_text_byte();
        if (delim_choices.size() > 0 && $urandom_range(99) < 40) begin
            return delim_choices[$urandom_range(delim_choices.size() - 1)];
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Mostly whole strings with random content; some set edits, ignored
    // items, stray bytes and strings left without a terminator.
    task automatic queue_random_traffic(input int count);
        int stop;
        int len;
        logic [7:0] value;
        stop = planned_items + count;
        while (planned_items < stop) begin
            case ($urandom_range(99)) inside
                [0:7]: begin
                    queue_item(OP_CLEAR, 8'($urandom_range(255)));
                    delim_choices.delete();
                    repeat ($urandom_range(1, 5)) begin
                        value = ($urandom_range(19) == 0) ? NUL_BYTE
                                                          : 8'($urandom_range(1, 255));
                        queue_item(OP_ADD, value);
                        delim_choices.push_back(value);
                    end
                end
                [8:13]: begin
                    case ($urandom_range(2))
                        0: queue_item(OP_UNUSED, 8'($urandom_range(255)));
                        1: begin
                            value = 8'($urandom_range(255));
                            queue_item(OP_ADD, value);
                            delim_choices.push_back(value);
                        end
                        default: queue_item(OP_TEXT, 8'($urandom_range(255)));
                    endcase
                end
                default: begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
                    repeat (len) queue_item(OP_TEXT, pick_text_byte());
                    if ($urandom_range(19) != 0) begin
                        queue_item(OP_TEXT, NUL_BYTE);
                    end
                end
            endcase
        end
    endtask

    // Hold the sender back until everything queued has been taken and reported.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_bytes.size() != 0 || i_s_tvalid || expected_tokens.size() != 0);
    endtask

    // Input side: predict each accepted item, then offer the next one.
    always @(posedge i_clk) begin : drive_input
        t_result    rpt;
        t_feed_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (tokenize_byte(i_s_tuser, i_s_tdata, rpt)) begin
                    expected_tokens.push_back(rpt);
                end
                items_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt.value;
                    i_s_tuser  <= nxt.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each accepted report with the oldest prediction.
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token report: start %0d length %0d",
                           o_m_tdata[15:0], o_m_tdata[31:16]);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_m_tuser[0] !== want.found) begin
                        $error("token_found: expected %0d, got %0d", want.found, o_m_tuser[0]);
                        mismatches++;
                    end
                    if (o_m_tdata[15:0] !== want.start) begin
                        $error("token_start: expected %0d, got %0d",
                               want.start, o_m_tdata[15:0]);
                        mismatches++;
                    end
                    if (o_m_tdata[31:16] !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, o_m_tdata[31:16]);
                        mismatches++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("string_end: expected %0d, got %0d", want.last, o_m_tlast);
                        mismatches++;
                    end
                    if (o_m_tuser[1] !== want.sat) begin
                        $error("position_saturated: expected %0d, got %0d",
                               want.sat, o_m_tuser[1]);
                        mismatches++;
                    end
                    if (want.sat) begin
                        saturated_reports++;
                    end
                end
                tokens_checked++;
            end
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: give up when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Reset once, then run the three idling phases.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idle_pct = 10;
        receiver_idle_pct = 61;

        // Directed items: an empty set, all-word strings, the empty string,
        // NUL and 0xFF in the set, ignored items and a mid-string edit.
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_TEXT, NUL_BYTE);
        queue_item(OP_TEXT, NUL_BYTE);
        queue_item(OP_ADD, 8'h20);
        queue_item(OP_ADD, NUL_BYTE);
        queue_item(OP_ADD, 8'hFF);
        queue_item(OP_UNUSED, 8'h20);
        queue_item(OP_TEXT, 8'h20);
        queue_item(OP_TEXT, 8'h01);
        queue_item(OP_TEXT, 8'h62);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_TEXT, 8'h20);
        queue_item(OP_ADD, 8'h63);
        queue_item(OP_TEXT, 8'h63);
        queue_item(OP_TEXT, 8'h64);
        queue_item(OP_TEXT, NUL_BYTE);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_TEXT, NUL_BYTE);
        queue_item(OP_CLEAR, 8'hFF);
        queue_item(OP_TEXT, 8'h20);
        queue_item(OP_UNUSED, 8'hFF);
        queue_item(OP_TEXT, NUL_BYTE);
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        sender_idle_pct = 61;
        receiver_idle_pct = 10;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        // Give any stray report time to show up.
        repeat (10) @(negedge i_clk);

        $display("run covered %0d input items and %0d token reports, %0d with saturation",
                 items_accepted, tokens_checked, saturated_reports);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/dst_pkg.sv
rtl/dst_front.sv
rtl/dst_queue.sv
rtl/dst_back.sv
rtl/delimiter_set_tokenizer_core.sv
rtl/dst_checker.sv
bench/tb.sv
